FILE: sv/axis_angle_rotation_matrix_unit_assert.svh
// assertion macros for the rotation matrix unit, used by its angle front end
// expects clk and rst_n in the scope where a macro is used
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AARM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AARM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/aarm_pkg.sv
// shared types, constants and tables of the axis-angle rotation matrix unit
// no dependencies
package aarm_pkg;

    // formats
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int AXIS_W        = 16;
    localparam int ANGLE_W       = 24;
    localparam int ENTRY_W       = 16;
    localparam int ENTRIES       = 9;
    localparam int Q30_W         = 34;
    localparam int IDX_W         = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int OMA_W         = Q30_W + AXIS_W;
    localparam int W_W           = OMA_W + AXIS_W;
    localparam int ACC_W         = (((31 + FRAC_BITS) > (61 - FRAC_BITS)) ?
                                    (31 + FRAC_BITS) : (61 - FRAC_BITS)) + 3;
    localparam int IN_TDATA_W    = 3 * AXIS_W + ANGLE_W;
    localparam int OUT_TDATA_W   = ENTRIES * ENTRY_W;

    // angle units of 1/256 degree
    localparam int FULL_TURN     = 92160;
    localparam int HALF_TURN     = 46080;
    localparam int QUARTER_TURN  = 23040;
    localparam int ANG_BIAS      = 92 * FULL_TURN;
    localparam longint unsigned RECIP_M = (64'd1 << 32) / FULL_TURN;
    localparam longint unsigned DEG2RAD_Q38 =
        ((64'd31415926 << 38) + 64'd230400000000) / 64'd460800000000;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    typedef logic signed [Q30_W-1:0]   q30_t;
    typedef logic signed [AXIS_W-1:0]  axis_t;
    typedef logic signed [OMA_W-1:0]   oma_t;
    typedef logic signed [W_W-1:0]     w_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [ENTRIES-1:0][ENTRY_W-1:0] mat_t;

    // rotator state held by one cell
    typedef struct packed {
        q30_t x;
        q30_t y;
        q30_t z;
    } cstate_t;

    // axis and quadrant flags riding alongside the rotator
    typedef struct packed {
        axis_t ax;
        axis_t ay;
        axis_t az;
        logic  sin_neg;
        logic  cos_neg;
    } side_t;

    // atan(2^-i) in q30
    function automatic q30_t atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 34'sd843314857;
            5'd1:    return 34'sd497837829;
            5'd2:    return 34'sd263043837;
            5'd3:    return 34'sd133525159;
            5'd4:    return 34'sd67021687;
            5'd5:    return 34'sd33543516;
            5'd6:    return 34'sd16775851;
            5'd7:    return 34'sd8388437;
            5'd8:    return 34'sd4194283;
            5'd9:    return 34'sd2097149;
            5'd10:   return 34'sd1048576;
            5'd11:   return 34'sd524288;
            5'd12:   return 34'sd262144;
            5'd13:   return 34'sd131072;
            5'd14:   return 34'sd65536;
            5'd15:   return 34'sd32768;
            5'd16:   return 34'sd16384;
            5'd17:   return 34'sd8192;
            5'd18:   return 34'sd4096;
            5'd19:   return 34'sd2048;
            5'd20:   return 34'sd1024;
            5'd21:   return 34'sd512;
            5'd22:   return 34'sd256;
            5'd23:   return 34'sd128;
            5'd24:   return 34'sd64;
            5'd25:   return 34'sd32;
            5'd26:   return 34'sd16;
            5'd27:   return 34'sd8;
            5'd28:   return 34'sd4;
            5'd29:   return 34'sd2;
            5'd30:   return 34'sd1;
            default: return 34'sd0;
        endcase
    endfunction

    // rotator gain in q30 for the number of stages, clamped to 8..16
    function automatic q30_t cordic_gain(input int stages);
        int gi;
        gi = (stages < 8) ? 0 : ((stages > 16) ? 8 : stages - 8);
        case (gi)
            0:       return 34'sd652039507;
            1:       return 34'sd652034532;
            2:       return 34'sd652033289;
            3:       return 34'sd652032978;
            4:       return 34'sd652032900;
            5:       return 34'sd652032881;
            6:       return 34'sd652032876;
            default: return 34'sd652032874;
        endcase
    endfunction

endpackage

FILE: sv/aarm_angle_reduce.sv
// angle front end: reduction modulo a full turn, quadrant fold, degrees to q30 radians
// depends on aarm_pkg and the assertion macro header
`include "axis_angle_rotation_matrix_unit_assert.svh"

module aarm_angle_reduce (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  aarm_pkg::axis_t                     axis_x,
    input  aarm_pkg::axis_t                     axis_y,
    input  aarm_pkg::axis_t                     axis_z,
    input  logic signed [aarm_pkg::ANGLE_W-1:0] angle_deg,
    output logic                                out_valid,
    output aarm_pkg::q30_t                      out_z,
    output aarm_pkg::side_t                     out_side
);
    import aarm_pkg::*;

    // stage 1 signals
    logic signed [25:0] v_sum;
    logic [24:0]        v_next;
    logic [40:0]        q_prod;
    logic [8:0]         q_next;
    side_t              s1_side_next;
    logic [24:0]        v_reg;
    logic [8:0]         q_reg;
    side_t              s1_side_reg;
    logic               s1_valid_reg;

    // stage 2 signals
    logic [24:0]        q_mult;
    logic [24:0]        r_raw;
    logic [16:0]        rem_next;
    logic [16:0]        rem_reg;
    side_t              s2_side_reg;
    logic               s2_valid_reg;

    // stage 3 signals
    logic [16:0]        t_wide;
    logic [15:0]        t_fold;
    logic [16:0]        m_wide;
    logic [14:0]        mag_next;
    side_t              s3_side_next;
    logic [14:0]        mag_reg;
    side_t              s3_side_reg;
    logic               s3_valid_reg;

    // stage 4 signals
    logic [39:0]        z_prod;
    logic [39:0]        z_rnd;
    q30_t               z_next;
    q30_t               z_reg;
    side_t              s4_side_reg;
    logic               s4_valid_reg;

    // bias to a positive value, estimate the turn count by reciprocal
    always_comb
    begin
        v_sum  = 26'(angle_deg) + 26'(ANG_BIAS);
        v_next = v_sum[24:0];
        q_prod = 41'(v_next) * 41'(RECIP_M[15:0]);
        q_next = q_prod[40:32];
        s1_side_next = '{ax: axis_x, ay: axis_y, az: axis_z, sin_neg: 1'b0, cos_neg: 1'b0};
    end

    // remainder with one correction step
    always_comb
    begin
        q_mult = 25'(q_reg) * 25'(FULL_TURN);
        r_raw  = v_reg - q_mult;
        if (r_raw >= 25'(FULL_TURN))
        begin
            rem_next = 17'(r_raw - 25'(FULL_TURN));
        end
        else
        begin
            rem_next = r_raw[16:0];
        end
    end

    // fold into a quarter turn, keep the signs of sine and cosine aside
    always_comb
    begin
        s3_side_next = s2_side_reg;
        t_wide       = 17'(FULL_TURN) - rem_reg;
        if (rem_reg < 17'(HALF_TURN))
        begin
            t_fold = rem_reg[15:0];
            s3_side_next.sin_neg = 1'b0;
        end
        else
        begin
            t_fold = t_wide[15:0];
            s3_side_next.sin_neg = 1'b1;
        end
        m_wide = 17'(HALF_TURN) - 17'(t_fold);
        if (t_fold > 16'(QUARTER_TURN))
        begin
            mag_next = m_wide[14:0];
            s3_side_next.cos_neg = 1'b1;
        end
        else
        begin
            mag_next = t_fold[14:0];
            s3_side_next.cos_neg = 1'b0;
        end
    end

    // degrees to q30 radians, rounded
    always_comb
    begin
        z_prod = 40'(mag_reg) * 40'(DEG2RAD_Q38[24:0]);
        z_rnd  = z_prod + 40'd128;
        z_next = {2'b00, z_rnd[39:8]};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg       <= v_next;
            q_reg       <= q_next;
            s1_side_reg <= s1_side_next;
            rem_reg     <= rem_next;
            s2_side_reg <= s1_side_reg;
            mag_reg     <= mag_next;
            s3_side_reg <= s3_side_next;
            z_reg       <= z_next;
            s4_side_reg <= s3_side_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_z     = z_reg;
    assign out_side  = s4_side_reg;

    // checks on the reduction
    `AARM_ASSERT_IMP(a_rem_range, s2_valid_reg, rem_reg < 17'(FULL_TURN), "remainder not below a full turn")
    `AARM_ASSERT_IMP(a_mag_range, s3_valid_reg, mag_reg <= 15'(QUARTER_TURN), "folded angle beyond a quarter turn")
    `AARM_ASSERT_NXT(a_z_follows, s3_valid_reg && en, s4_valid_reg, "folded word lost before radians stage")

endmodule

FILE: sv/aarm_cordic_cell.sv
// one rotation-mode cordic cell: a single micro-rotation per cycle while en is high
// depends on aarm_pkg
module aarm_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  aarm_pkg::cstate_t             in_st,
    input  aarm_pkg::side_t               in_side,
    input  logic [aarm_pkg::IDX_W-1:0]    shift,
    input  aarm_pkg::q30_t                atan_step,
    output logic                          out_valid,
    output aarm_pkg::cstate_t             out_st,
    output aarm_pkg::side_t               out_side
);
    import aarm_pkg::*;

    q30_t    dx;
    q30_t    dy;
    cstate_t st_next;
    cstate_t st_reg;
    side_t   side_reg;
    logic    valid_reg;

    // micro-rotation, direction from the sign of the residual angle
    always_comb
    begin
        dx = in_st.y >>> shift;
        dy = in_st.x >>> shift;
        if (!in_st.z[Q30_W-1])
        begin
            st_next.x = in_st.x - dx;
            st_next.y = in_st.y + dy;
            st_next.z = in_st.z - atan_step;
        end
        else
        begin
            st_next.x = in_st.x + dx;
            st_next.y = in_st.y - dy;
            st_next.z = in_st.z + atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg   <= st_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/aarm_matrix_build.sv
// matrix assembly: c*I + (1-c)*a*a^T + s*K(a), rounded and saturated to q2.14
// depends on aarm_pkg
module aarm_matrix_build (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  aarm_pkg::cstate_t   in_st,
    input  aarm_pkg::side_t     in_side,
    output logic                out_valid,
    output aarm_pkg::mat_t      out_m
);
    import aarm_pkg::*;

    // stage 1: signed sine, cosine and one minus cosine
    q30_t  c_next;
    q30_t  s_next;
    q30_t  omc_next;
    q30_t  c1_reg;
    q30_t  s1_reg;
    q30_t  omc1_reg;
    axis_t a1_reg [3];
    logic  v1_reg;

    // stage 2: first products
    oma_t  u_next [3];
    oma_t  t_next [3];
    q30_t  c2_reg;
    oma_t  u2_reg [3];
    oma_t  t2_reg [3];
    axis_t a2_reg [3];
    logic  v2_reg;

    // stage 3: second products of the symmetric part
    w_t    w_next [6];
    q30_t  c3_reg;
    oma_t  t3_reg [3];
    w_t    w3_reg [6];
    logic  v3_reg;

    // stage 4: full precision sums
    acc_t  cd;
    acc_t  acc_next [ENTRIES];
    acc_t  acc4_reg [ENTRIES];
    logic  v4_reg;

    // stage 5: rounding and saturation
    acc_t  r_sh [ENTRIES];
    mat_t  mat_next;
    mat_t  mat_reg;
    logic  v5_reg;

    function automatic acc_t round_frac(input w_t v);
        return acc_t'((v + (w_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    always_comb
    begin
        c_next   = in_side.cos_neg ? -in_st.x : in_st.x;
        s_next   = in_side.sin_neg ? -in_st.y : in_st.y;
        omc_next = (q30_t'(1) <<< 30) - c_next;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = oma_t'(omc1_reg) * oma_t'(a1_reg[i]);
            t_next[i] = oma_t'(s1_reg) * oma_t'(a1_reg[i]);
        end
    end

    // pair order: 00 11 22 01 02 12
    always_comb
    begin
        w_next[0] = w_t'(u2_reg[0]) * w_t'(a2_reg[0]);
        w_next[1] = w_t'(u2_reg[1]) * w_t'(a2_reg[1]);
        w_next[2] = w_t'(u2_reg[2]) * w_t'(a2_reg[2]);
        w_next[3] = w_t'(u2_reg[0]) * w_t'(a2_reg[1]);
        w_next[4] = w_t'(u2_reg[0]) * w_t'(a2_reg[2]);
        w_next[5] = w_t'(u2_reg[1]) * w_t'(a2_reg[2]);
    end

    // diagonal takes the cosine, off-diagonal the skew term
    always_comb
    begin
        cd          = acc_t'(c3_reg) <<< FRAC_BITS;
        acc_next[0] = round_frac(w3_reg[0]) + cd;
        acc_next[4] = round_frac(w3_reg[1]) + cd;
        acc_next[8] = round_frac(w3_reg[2]) + cd;
        acc_next[1] = round_frac(w3_reg[3]) - acc_t'(t3_reg[2]);
        acc_next[3] = round_frac(w3_reg[3]) + acc_t'(t3_reg[2]);
        acc_next[2] = round_frac(w3_reg[4]) + acc_t'(t3_reg[1]);
        acc_next[6] = round_frac(w3_reg[4]) - acc_t'(t3_reg[1]);
        acc_next[5] = round_frac(w3_reg[5]) - acc_t'(t3_reg[0]);
        acc_next[7] = round_frac(w3_reg[5]) + acc_t'(t3_reg[0]);
    end

    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            r_sh[e] = (acc4_reg[e] + (acc_t'(1) <<< 29)) >>> 30;
            if (r_sh[e] > acc_t'(SAT_MAX))
            begin
                mat_next[e] = ENTRY_W'(SAT_MAX);
            end
            else if (r_sh[e] < acc_t'(SAT_MIN))
            begin
                mat_next[e] = ENTRY_W'(SAT_MIN);
            end
            else
            begin
                mat_next[e] = r_sh[e][ENTRY_W-1:0];
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg    <= c_next;
            s1_reg    <= s_next;
            omc1_reg  <= omc_next;
            a1_reg[0] <= in_side.ax;
            a1_reg[1] <= in_side.ay;
            a1_reg[2] <= in_side.az;
            c2_reg    <= c1_reg;
            u2_reg    <= u_next;
            t2_reg    <= t_next;
            a2_reg    <= a1_reg;
            c3_reg    <= c2_reg;
            t3_reg    <= t2_reg;
            w3_reg    <= w_next;
            acc4_reg  <= acc_next;
            mat_reg   <= mat_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_m     = mat_reg;

endmodule

FILE: sv/axis_angle_rotation_matrix_unit.sv
// top level of the axis-angle rotation matrix unit
// depends on aarm_pkg, aarm_angle_reduce, aarm_cordic_cell, aarm_matrix_build
//
// usage
//   s_axis carries one word per rotation: axis x, y, z (q2.14) and the angle in
//   degrees (q16.8). m_axis returns one word per input word with the nine entries
//   of the rotation matrix in row-major order, q2.14, saturated.
//   from input acceptance to m_axis_tvalid a word passes through angle reduction,
//   the 16 cordic cells, and the matrix products and rounding, in that order.
//   throughput is one word per cycle unless m_axis_tready stalls the pipeline;
//   the row of cordic cells and the multiplier stages each hold a different
//   word, so a new word enters every cycle while the pipeline is not stalled.
//   every word is independent, there is no kept state between words.
//   reset clears every valid flag; the pipeline comes up empty and s_axis_tready
//   is high from the first cycle after reset.
//   when the receiver holds m_axis_tready low with a word waiting, the whole
//   pipeline freezes and s_axis_tready drops in the same cycle; words already
//   inside keep their places and nothing is lost or repeated.
module axis_angle_rotation_matrix_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // axis_x[15:0], axis_y[31:16], axis_z[47:32], angle_deg[71:48]
    input  logic [aarm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each from bit 0 up
    output logic [aarm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import aarm_pkg::*;

    logic    en;
    logic    ang_valid;
    q30_t    ang_z;
    side_t   ang_side;
    logic    cell_valid [CORDIC_STAGES+1];
    cstate_t cell_st    [CORDIC_STAGES+1];
    side_t   cell_side  [CORDIC_STAGES+1];
    mat_t    mat;

    // pipeline advances unless a finished word is held at the output
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // angle front end
    aarm_angle_reduce u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .axis_x    (s_axis_tdata[AXIS_W-1:0]),
        .axis_y    (s_axis_tdata[2*AXIS_W-1:AXIS_W]),
        .axis_z    (s_axis_tdata[3*AXIS_W-1:2*AXIS_W]),
        .angle_deg (s_axis_tdata[IN_TDATA_W-1:3*AXIS_W]),
        .out_valid (ang_valid),
        .out_z     (ang_z),
        .out_side  (ang_side)
    );

    // rotator starts at the gain on the x axis
    assign cell_valid[0] = ang_valid;
    assign cell_st[0]    = '{x: cordic_gain(CORDIC_STAGES), y: '0, z: ang_z};
    assign cell_side[0]  = ang_side;

    // row of cordic cells
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        aarm_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_st     (cell_st[i]),
            .in_side   (cell_side[i]),
            .shift     (IDX_W'(i)),
            .atan_step (atan_q30(5'(i))),
            .out_valid (cell_valid[i+1]),
            .out_st    (cell_st[i+1]),
            .out_side  (cell_side[i+1])
        );
    end

    // matrix assembly and output register
    aarm_matrix_build u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cell_valid[CORDIC_STAGES]),
        .in_st     (cell_st[CORDIC_STAGES]),
        .in_side   (cell_side[CORDIC_STAGES]),
        .out_valid (m_axis_tvalid),
        .out_m     (mat)
    );

    assign m_axis_tdata = mat;

endmodule
